FILE: src/ssc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared widths, register indexes, mode codes and constants of the shading
// correction block.
// ----------------------------------------------------------------------------
package ssc_pkg;

    localparam int PIXEL_W    = 8;
    localparam int OUT_COL_W  = 13;
    localparam int MODE_W     = 2;
    localparam int DEC_W      = 4;
    localparam int LEN_W      = 14;
    localparam int CFG_DATA_W = 14;
    localparam int CFG_IDX_W  = 2;

    localparam int DEFAULT_MAX_LINE_PIXELS = 8192;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH = 2'd2;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_PASS      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CALIBRATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CORRECT   = 2'd2;

    // request codes
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    localparam logic [MODE_W-1:0]  MODE_RESET = MODE_PASS;
    localparam logic [DEC_W-1:0]   DEC_RESET  = 4'd2;
    localparam logic [DEC_W-1:0]   DEC_MAX    = 4'd12;
    localparam logic [LEN_W-1:0]   LEN_RESET  = 14'd5300;

    localparam logic [PIXEL_W-1:0] PEAK_CLEAR      = 8'd1;
    localparam logic [PIXEL_W-1:0] PIXEL_MAX       = 8'd255;
    localparam logic [PIXEL_W-1:0] GAIN_LIMIT_PEAK = 8'd127;

    localparam int DIV_STEPS = PIXEL_W;

endpackage
`default_nettype wire

FILE: src/ssc_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_sample_if / ssc_result_if
// Valid/ready channels carrying raw samples in and corrected pixels out.
// ----------------------------------------------------------------------------
interface ssc_sample_if;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [ssc_pkg::PIXEL_W-1:0]  pixel;

    modport source (output valid, output req_type, output pixel, input ready);
    modport sink   (input valid, input req_type, input pixel, output ready);
endinterface

interface ssc_result_if;
    logic                          valid;
    logic                          ready;
    logic [ssc_pkg::PIXEL_W-1:0]   pixel_out;
    logic [ssc_pkg::OUT_COL_W-1:0] out_column;
    logic                          last_of_line;

    modport source (output valid, output pixel_out, output out_column, output last_of_line,
                    input ready);
    modport sink   (input valid, input pixel_out, input out_column, input last_of_line,
                    output ready);
endinterface
`default_nettype wire

FILE: src/scanner_shading_correction.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scanner_shading_correction
// Flat-field shading correction for a line sensor: per-column peak memory,
// calibrate pass, and corrected, decimated output with an 8-step divider.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  sample    in   valid/ready    req_type, pixel
//  result    out  valid/ready    pixel_out, out_column, last_of_line
//  cfg       in   cfg_we         cfg_index, cfg_data
//
//  pass, calibrate and plain corrected pixels go through accept, peak
//  memory read and result; corrected pixels needing a divide add 8
//  restoring divide steps. a clear item and reset start a fill pass
//  writing 1 to every peak entry, no sample taken. every config write
//  reruns a column/decimation divide before the next sample. result is
//  held in an output register, so a stalled result side blocks only
//  after the next item finishes.
// ----------------------------------------------------------------------------
module scanner_shading_correction #(
    parameter int MAX_LINE_PIXELS = ssc_pkg::DEFAULT_MAX_LINE_PIXELS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ssc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssc_pkg::CFG_DATA_W-1:0] cfg_data,
    ssc_sample_if.sink                     sample,
    ssc_result_if.source                   result
);
    import ssc_pkg::*;

    localparam int CW      = $clog2(MAX_LINE_PIXELS);
    localparam int LW      = $clog2(MAX_LINE_PIXELS + 1);
    localparam int StepW   = $clog2(LW + 1);
    localparam int DivCntW = $clog2(DIV_STEPS);
    localparam logic [CW-1:0]      LastAddr = CW'(MAX_LINE_PIXELS - 1);
    localparam logic [StepW-1:0]   RcLast   = StepW'(LW - 1);
    localparam logic [DivCntW-1:0] DivLast  = DivCntW'(DIV_STEPS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_EMIT
    } state_t;

    state_t                 state_reg;

    logic [MODE_W-1:0]      mode_reg;
    logic [DEC_W-1:0]       dec_reg;
    logic [LEN_W-1:0]       len_reg;

    logic [CW-1:0]          col_reg;
    logic [DEC_W-1:0]       phase_reg;
    logic [CW-1:0]          k_reg;
    logic [LW-1:0]          outs_reg;

    logic                   clr_active_reg;
    logic [CW-1:0]          clr_addr_reg;

    logic                   rc_start_reg;
    logic                   rc_active_reg;
    logic [StepW-1:0]       rc_cnt_reg;
    logic [LW-1:0]          rc_len_num_reg;
    logic [DEC_W-1:0]       rc_len_rem_reg;
    logic [LW-1:0]          rc_col_num_reg;
    logic [DEC_W-1:0]       rc_col_rem_reg;

    logic [PIXEL_W-1:0]     pix_reg;
    logic [CW-1:0]          col_cur_reg;
    logic [DEC_W-1:0]       phase_cur_reg;
    logic [CW-1:0]          k_cur_reg;

    logic [PIXEL_W-1:0]     div_rem_reg;
    logic [PIXEL_W-1:0]     div_q_reg;
    logic [DivCntW-1:0]     div_cnt_reg;

    logic [PIXEL_W-1:0]     res_pix_reg;
    logic [OUT_COL_W-1:0]   res_col_reg;
    logic                   res_last_reg;

    logic                   out_valid_reg;
    logic [PIXEL_W-1:0]     out_pix_reg;
    logic [OUT_COL_W-1:0]   out_col_reg;
    logic                   out_last_reg;

    logic [PIXEL_W-1:0]     peak_mem [MAX_LINE_PIXELS];
    logic [PIXEL_W-1:0]     peak_rd_reg;

    logic [LW-1:0]          len_eff;
    logic [DEC_W-1:0]       dec_eff;
    logic                   busy;
    logic                   accept;
    logic                   line_wrap;
    logic [CW-1:0]          col_use;
    logic [DEC_W-1:0]       phase_use;
    logic [CW-1:0]          k_use;

    logic [LW-1:0]          col_plus;
    logic                   end_of_line;
    logic                   raw_last;
    logic                   emit_corr;
    logic                   corr_last;
    logic                   need_div;
    logic [PIXEL_W-1:0]     direct_pix;
    logic [2*PIXEL_W-1:0]   prod255;
    logic [DEC_W-1:0]       phase_inc;

    logic [PIXEL_W:0]       div_trial;
    logic                   div_ge;
    logic [PIXEL_W-1:0]     div_rem_next;

    logic [DEC_W:0]         len_trial;
    logic                   len_ge;
    logic [DEC_W-1:0]       len_rem_next;
    logic [LW-1:0]          len_num_next;
    logic [DEC_W:0]         colq_trial;
    logic                   colq_ge;
    logic [DEC_W-1:0]       colq_rem_next;
    logic [LW-1:0]          colq_num_next;

    logic                   mem_we;
    logic [CW-1:0]          mem_wa;
    logic [PIXEL_W-1:0]     mem_wd;
    logic                   out_load;

    // effective register values
    always_comb
    begin
        if (len_reg == '0)
            len_eff = LW'(1);
        else if (32'(len_reg) > 32'(MAX_LINE_PIXELS))
            len_eff = LW'(MAX_LINE_PIXELS);
        else
            len_eff = LW'(len_reg);

        if (dec_reg == '0)
            dec_eff = DEC_W'(1);
        else if (dec_reg > DEC_MAX)
            dec_eff = DEC_MAX;
        else
            dec_eff = dec_reg;
    end

    assign busy      = clr_active_reg | rc_start_reg | rc_active_reg;
    assign sample.ready = (state_reg == S_IDLE) && !busy;
    assign accept    = sample.valid && sample.ready;

    // a column counter past the line end restarts the line
    assign line_wrap = LW'(col_reg) >= len_eff;
    assign col_use   = line_wrap ? '0 : col_reg;
    assign phase_use = line_wrap ? '0 : phase_reg;
    assign k_use     = line_wrap ? '0 : k_reg;

    // per-item decode after the peak read
    assign col_plus    = LW'(col_cur_reg) + LW'(1);
    assign end_of_line = col_plus >= len_eff;
    assign raw_last    = col_plus == len_eff;
    assign emit_corr   = (phase_cur_reg == '0) && (LW'(k_cur_reg) < outs_reg);
    assign corr_last   = (LW'(k_cur_reg) + LW'(1)) == outs_reg;
    assign need_div    = (peak_rd_reg > GAIN_LIMIT_PEAK) && (pix_reg < peak_rd_reg);
    assign phase_inc   = phase_cur_reg + DEC_W'(1);
    assign prod255     = {pix_reg, {PIXEL_W{1'b0}}} - {{PIXEL_W{1'b0}}, pix_reg};

    always_comb
    begin
        if (peak_rd_reg <= GAIN_LIMIT_PEAK)
            direct_pix = pix_reg[PIXEL_W-1] ? PIXEL_MAX : {pix_reg[PIXEL_W-2:0], 1'b0};
        else
            direct_pix = PIXEL_MAX;
    end

    // one restoring divide step of 255*p by the peak
    assign div_trial    = {div_rem_reg, div_q_reg[PIXEL_W-1]};
    assign div_ge       = div_trial >= {1'b0, peak_rd_reg};
    assign div_rem_next = div_ge ? PIXEL_W'(div_trial - {1'b0, peak_rd_reg})
                                 : div_trial[PIXEL_W-1:0];

    // one restoring divide step each of line length and column by decimation
    assign len_trial     = {rc_len_rem_reg, rc_len_num_reg[LW-1]};
    assign len_ge        = len_trial >= {1'b0, dec_eff};
    assign len_rem_next  = len_ge ? DEC_W'(len_trial - {1'b0, dec_eff})
                                  : len_trial[DEC_W-1:0];
    assign len_num_next  = {rc_len_num_reg[LW-2:0], len_ge};
    assign colq_trial    = {rc_col_rem_reg, rc_col_num_reg[LW-1]};
    assign colq_ge       = colq_trial >= {1'b0, dec_eff};
    assign colq_rem_next = colq_ge ? DEC_W'(colq_trial - {1'b0, dec_eff})
                                   : colq_trial[DEC_W-1:0];
    assign colq_num_next = {rc_col_num_reg[LW-2:0], colq_ge};

    // peak memory write port
    always_comb
    begin
        if (clr_active_reg)
        begin
            mem_we = 1'b1;
            mem_wa = clr_addr_reg;
            mem_wd = PEAK_CLEAR;
        end
        else
        begin
            mem_we = (state_reg == S_READ) && (mode_reg == MODE_CALIBRATE) &&
                     (pix_reg > peak_rd_reg);
            mem_wa = col_cur_reg;
            mem_wd = pix_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            peak_mem[mem_wa] <= mem_wd;
        if (accept)
            peak_rd_reg <= peak_mem[col_use];
    end

    assign out_load = (state_reg == S_EMIT) && (!out_valid_reg || result.ready);

    assign result.valid        = out_valid_reg;
    assign result.pixel_out    = out_pix_reg;
    assign result.out_column   = out_col_reg;
    assign result.last_of_line = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= MODE_RESET;
            dec_reg        <= DEC_RESET;
            len_reg        <= LEN_RESET;
            col_reg        <= '0;
            phase_reg      <= '0;
            k_reg          <= '0;
            outs_reg       <= '0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            rc_start_reg   <= 1'b1;
            rc_active_reg  <= 1'b0;
            rc_cnt_reg     <= '0;
            rc_len_num_reg <= '0;
            rc_len_rem_reg <= '0;
            rc_col_num_reg <= '0;
            rc_col_rem_reg <= '0;
            pix_reg        <= '0;
            col_cur_reg    <= '0;
            phase_cur_reg  <= '0;
            k_cur_reg      <= '0;
            div_rem_reg    <= '0;
            div_q_reg      <= '0;
            div_cnt_reg    <= '0;
            res_pix_reg    <= '0;
            res_col_reg    <= '0;
            res_last_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_pix_reg    <= '0;
            out_col_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            // peak fill pass
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + CW'(1);
                if (clr_addr_reg == LastAddr)
                    clr_active_reg <= 1'b0;
            end

            // decimation position and output count after a register change
            if (rc_start_reg)
            begin
                rc_start_reg   <= 1'b0;
                rc_active_reg  <= 1'b1;
                rc_cnt_reg     <= '0;
                rc_len_num_reg <= len_eff;
                rc_len_rem_reg <= '0;
                rc_col_num_reg <= LW'(col_reg);
                rc_col_rem_reg <= '0;
            end
            else if (rc_active_reg)
            begin
                rc_cnt_reg     <= rc_cnt_reg + StepW'(1);
                rc_len_num_reg <= len_num_next;
                rc_len_rem_reg <= len_rem_next;
                rc_col_num_reg <= colq_num_next;
                rc_col_rem_reg <= colq_rem_next;
                if (rc_cnt_reg == RcLast)
                begin
                    rc_active_reg <= 1'b0;
                    outs_reg      <= len_num_next;
                    k_reg         <= CW'(colq_num_next);
                    phase_reg     <= colq_rem_next;
                end
            end

            if (cfg_we)
            begin
                rc_start_reg <= 1'b1;
                unique case (cfg_index)
                    CFG_MODE:        mode_reg <= cfg_data[MODE_W-1:0];
                    CFG_DECIMATION:  dec_reg  <= cfg_data[DEC_W-1:0];
                    CFG_LINE_LENGTH: len_reg  <= cfg_data[LEN_W-1:0];
                    default:         ;
                endcase
            end

            if (result.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (sample.req_type == REQ_CLEAR)
                        begin
                            clr_active_reg <= 1'b1;
                            clr_addr_reg   <= '0;
                            col_reg        <= '0;
                            phase_reg      <= '0;
                            k_reg          <= '0;
                        end
                        else
                        begin
                            pix_reg       <= sample.pixel;
                            col_cur_reg   <= col_use;
                            phase_cur_reg <= phase_use;
                            k_cur_reg     <= k_use;
                            state_reg     <= S_READ;
                        end
                    end
                end

                S_READ:
                begin
                    if (end_of_line)
                    begin
                        col_reg   <= '0;
                        phase_reg <= '0;
                        k_reg     <= '0;
                    end
                    else
                    begin
                        col_reg <= CW'(col_plus);
                        if (phase_inc == dec_eff)
                        begin
                            phase_reg <= '0;
                            k_reg     <= k_cur_reg + CW'(1);
                        end
                        else
                        begin
                            phase_reg <= phase_inc;
                            k_reg     <= k_cur_reg;
                        end
                    end

                    if (mode_reg == MODE_CORRECT)
                    begin
                        res_col_reg  <= OUT_COL_W'(k_cur_reg);
                        res_last_reg <= corr_last;
                        if (!emit_corr)
                            state_reg <= S_IDLE;
                        else if (need_div)
                        begin
                            div_rem_reg <= prod255[2*PIXEL_W-1:PIXEL_W];
                            div_q_reg   <= prod255[PIXEL_W-1:0];
                            div_cnt_reg <= '0;
                            state_reg   <= S_DIV;
                        end
                        else
                        begin
                            res_pix_reg <= direct_pix;
                            state_reg   <= S_EMIT;
                        end
                    end
                    else
                    begin
                        res_pix_reg  <= pix_reg;
                        res_col_reg  <= OUT_COL_W'(col_cur_reg);
                        res_last_reg <= raw_last;
                        state_reg    <= S_EMIT;
                    end
                end

                S_DIV:
                begin
                    div_rem_reg <= div_rem_next;
                    div_q_reg   <= {div_q_reg[PIXEL_W-2:0], div_ge};
                    div_cnt_reg <= div_cnt_reg + DivCntW'(1);
                    if (div_cnt_reg == DivLast)
                    begin
                        res_pix_reg <= {div_q_reg[PIXEL_W-2:0], div_ge};
                        state_reg   <= S_EMIT;
                    end
                end

                S_EMIT:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        out_pix_reg   <= res_pix_reg;
                        out_col_reg   <= res_col_reg;
                        out_last_reg  <= res_last_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // divider runs only for a peak above the gain limit and a smaller sample
    a_div_operands: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> (peak_rd_reg > GAIN_LIMIT_PEAK) && (pix_reg < peak_rd_reg))
        else $error("divide started with out-of-range operands");

    a_column_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> LW'(col_cur_reg) < len_eff)
        else $error("column beyond line length");

    a_phase_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) && !busy |-> phase_reg < dec_eff)
        else $error("decimation phase out of range");

    a_fill_pass_ends: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg && (clr_addr_reg == LastAddr) |=> !clr_active_reg)
        else $error("peak fill pass did not end");

endmodule
`default_nettype wire
